// File: hw/rtl/multi_key_vigenere_encrypt_defines.svh
// Assertion macros shared by the multi-key Vigenere encryptor RTL.
// No dependencies; the using module must have clk_i and rst_ni in scope.
`ifndef MULTI_KEY_VIGENERE_ENCRYPT_DEFINES_SVH
`define MULTI_KEY_VIGENERE_ENCRYPT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define MKV_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define MKV_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/mkv_pkg.sv
// Package for the multi-key Vigenere encryptor: operation codes, queue entry type,
// character constants and the modulo-26 reduction. No dependencies.
package mkv_pkg;

  // Input command codes.
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_ENCRYPT = 1'b1;

  // Character constants.
  localparam logic [7:0] ASCII_A = 8'd97;
  localparam logic [7:0] ASCII_Z = 8'd122;
  localparam int unsigned ALPHA  = 26;

  // Letter sum of up to eight 5-bit letters, and the offset plus that sum.
  localparam int unsigned SUM_W = 8;
  localparam int unsigned MOD_W = 9;

  // Reciprocal of 26 as 79 / 2^11; exact quotient for inputs up to 337.
  localparam int unsigned RECIP_MUL   = 79;
  localparam int unsigned RECIP_SHIFT = 11;

  // Queue between the front and the back.
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = 2;
  localparam int unsigned Q_CW    = 3;

  // Classified operation carried through the queue.
  typedef enum logic [1:0] {
    OP_LOAD,
    OP_LETTER,
    OP_PASS
  } mkv_op_e;

  typedef struct packed {
    mkv_op_e     op;
    logic [2:0]  slot;
    logic [3:0]  pos;
    logic [4:0]  letter;
    logic        key_end;
    logic [7:0]  data;
  } mkv_op_t;

  // Remainder modulo 26 by reciprocal multiply and one correction step.
  function automatic logic [4:0] mod_alpha(input logic [MOD_W-1:0] x);
    logic [14:0]      prod;
    logic [3:0]       quo;
    logic [MOD_W-1:0] rem;
    prod = 15'(x) * 15'(RECIP_MUL);
    quo  = 4'(prod >> RECIP_SHIFT);
    rem  = x - MOD_W'(quo) * MOD_W'(ALPHA);
    if (rem >= MOD_W'(ALPHA)) begin
      rem = rem - MOD_W'(ALPHA);
    end
    return rem[4:0];
  endfunction

endpackage

// File: hw/rtl/multi_key_vigenere_encrypt.sv
// Top level of the multi-key Vigenere encryptor: configuration register and the
// front, queue and back. Depends on mkv_pkg, mkv_front, mkv_queue and mkv_back.
//
// Usage:
//   The input channel (in_valid_i / in_ready_o) carries one transaction per item:
//   a key letter load (command 0) or a data byte to encrypt (command 1).
//   Loads give no result; every data byte gives one cipher byte on the output
//   channel (out_valid_o / out_ready_i), in input order.
//   The configuration channel (cfg_valid_i / cfg_ready_o) writes keys_in_use and
//   is always ready; write it only while the block is idle.
//   A data byte passes the queue, the result stage and the output register.
//   Throughput: one item per cycle while the output is not stalled; each letter
//   reads all key lanes in parallel and the cursor of every key in use steps
//   in the same cycle. A four-entry queue separates the front from the back, so
//   input keeps flowing while the receiver stalls until the queue is full; then
//   in_ready_o drops and the output holds its transaction until it is taken.
//   Reset: every key length is one, every cursor zero, keys_in_use is one.
//   Key letters are undefined until loaded.
module multi_key_vigenere_encrypt #(
  parameter int unsigned MAX_KEYS = 8,
  parameter int unsigned KEY_LEN  = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [3:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       command_i,
  input  logic [2:0] key_slot_i,
  input  logic [3:0] key_position_i,
  input  logic [4:0] key_letter_i,
  input  logic       key_end_i,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] cipher_byte_o
);
  import mkv_pkg::*;

  logic [3:0] keys_in_use_reg_q;
  logic       push;
  logic       q_full;
  logic       pop;
  logic       head_valid;
  mkv_op_t    entry;
  mkv_op_t    head;

  // Configuration register.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keys_in_use_reg_q <= 4'd1;
    end else if (cfg_valid_i) begin
      keys_in_use_reg_q <= cfg_data_i;
    end
  end

  // Accept and classify input transactions.
  mkv_front #(
    .MAX_KEYS(MAX_KEYS),
    .KEY_LEN (KEY_LEN)
  ) u_front (
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .key_slot_i     (key_slot_i),
    .key_position_i (key_position_i),
    .key_letter_i   (key_letter_i),
    .key_end_i      (key_end_i),
    .data_byte_i    (data_byte_i),
    .q_full_i       (q_full),
    .push_o         (push),
    .entry_o        (entry)
  );

  // Queue between front and back.
  mkv_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .entry_i      (entry),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  // Execute loads and encryptions.
  mkv_back #(
    .MAX_KEYS(MAX_KEYS),
    .KEY_LEN (KEY_LEN)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .keys_in_use_i (keys_in_use_reg_q),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .cipher_byte_o (cipher_byte_o)
  );

endmodule

// File: hw/rtl/mkv_front.sv
// Front end of the multi-key Vigenere encryptor: accepts input transactions and
// classifies them into queue entries. Depends on mkv_pkg.
module mkv_front #(
  parameter int unsigned MAX_KEYS = 8,
  parameter int unsigned KEY_LEN  = 16
) (
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           command_i,
  input  logic [2:0]     key_slot_i,
  input  logic [3:0]     key_position_i,
  input  logic [4:0]     key_letter_i,
  input  logic           key_end_i,
  input  logic [7:0]     data_byte_i,
  input  logic           q_full_i,
  output logic           push_o,
  output mkv_pkg::mkv_op_t entry_o
);
  import mkv_pkg::*;

  logic drop;

  // A load aimed outside the key store is taken and then discarded.
  assign drop = (command_i == CMD_LOAD) &&
                (({1'b0, key_slot_i} >= 4'(MAX_KEYS)) ||
                 ({1'b0, key_position_i} >= 5'(KEY_LEN)));

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i && !drop;

  // Classify the transaction and pack the entry.
  always_comb begin
    entry_o.slot    = key_slot_i;
    entry_o.pos     = key_position_i;
    entry_o.letter  = key_letter_i;
    entry_o.key_end = key_end_i;
    entry_o.data    = data_byte_i;
    if (command_i == CMD_LOAD) begin
      entry_o.op = OP_LOAD;
    end else if (data_byte_i inside {[ASCII_A:ASCII_Z]}) begin
      entry_o.op = OP_LETTER;
    end else begin
      entry_o.op = OP_PASS;
    end
  end

endmodule

// File: hw/rtl/mkv_queue.sv
// Short FIFO between the front and back of the multi-key Vigenere encryptor.
// Depends on mkv_pkg and the shared assertion macros.
`include "multi_key_vigenere_encrypt_defines.svh"

module mkv_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  mkv_pkg::mkv_op_t entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             head_valid_o,
  output mkv_pkg::mkv_op_t head_o
);
  import mkv_pkg::*;

  mkv_op_t         mem_q [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [Q_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [Q_CW-1:0] count_q, count_d;

  assign full_o       = (count_q == Q_CW'(Q_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  `MKV_ASSERT_IMPL(a_q_bound, 1'b1, count_q <= Q_CW'(Q_DEPTH), "queue fill count past depth")
  `MKV_ASSERT_NEXT(a_q_grow, push_i && !pop_i, count_q == $past(count_q) + 1'b1, "queue push lost")

endmodule

// File: hw/rtl/mkv_back.sv
// Back end of the multi-key Vigenere encryptor: key store, key cursors, letter
// sum, modulo-26 shift and the output register. Depends on mkv_pkg and the macros.
`include "multi_key_vigenere_encrypt_defines.svh"

module mkv_back #(
  parameter int unsigned MAX_KEYS = 8,
  parameter int unsigned KEY_LEN  = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [3:0]       keys_in_use_i,
  input  logic             head_valid_i,
  input  mkv_pkg::mkv_op_t head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       cipher_byte_o
);
  import mkv_pkg::*;

  localparam int unsigned SLOT_W = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int unsigned CUR_W  = (KEY_LEN > 1) ? $clog2(KEY_LEN) : 1;
  localparam int unsigned LEN_W  = $clog2(KEY_LEN + 1);
  localparam int unsigned CMP_W  = (CUR_W + 1 > LEN_W) ? CUR_W + 1 : LEN_W;

  // Per-key state.
  logic [CUR_W-1:0] cursor_q [MAX_KEYS];
  logic [LEN_W-1:0] length_q [MAX_KEYS];
  logic [4:0]       lane_letter [MAX_KEYS];

  logic             is_load;
  logic             load_fire;
  logic             enc_fire;
  logic             end_fire;
  logic [3:0]       n_use;
  logic [SLOT_W-1:0] wr_slot;
  logic [CUR_W-1:0] wr_pos;
  logic [SUM_W-1:0] sum;

  // Result stage between execution and the output register.
  logic             r1_valid_q;
  logic             r1_letter_q;
  logic [7:0]       r1_byte_q;
  logic [SUM_W-1:0] r1_sum_q;
  logic             r1_ready;

  logic             out_valid_q;
  logic [7:0]       out_byte_q;
  logic             out_load;
  logic [MOD_W-1:0] mod_in;
  logic [7:0]       offset;
  logic [7:0]       cipher;

  // Handshake between the queue head, the result stage and the output register.
  assign out_load  = !out_valid_q || out_ready_i;
  assign r1_ready  = !r1_valid_q || out_load;
  assign is_load   = (head_i.op == OP_LOAD);
  assign pop_o     = head_valid_i && (is_load || r1_ready);
  assign load_fire = pop_o && is_load;
  assign enc_fire  = pop_o && (head_i.op == OP_LETTER);
  assign end_fire  = load_fire && head_i.key_end;
  assign wr_slot   = head_i.slot[SLOT_W-1:0];
  assign wr_pos    = head_i.pos[CUR_W-1:0];

  // Key count saturates at the number of slots.
  assign n_use = (keys_in_use_i > 4'(MAX_KEYS)) ? 4'(MAX_KEYS) : keys_in_use_i;

  for (genvar s = 0; s < MAX_KEYS; s++) begin : g_lane
    logic [4:0]       store_q [KEY_LEN];
    logic [CUR_W-1:0] cur_idx;
    logic [CMP_W-1:0] nxt;
    logic             lane_on;
    logic             wrap;
    logic             sel;

    assign sel     = (wr_slot == SLOT_W'(s));
    assign lane_on = (4'(s) < n_use);
    assign cur_idx = (CMP_W'(cursor_q[s]) >= CMP_W'(KEY_LEN)) ? '0 : cursor_q[s];
    assign nxt     = CMP_W'(cur_idx) + 1'b1;
    assign wrap    = (nxt >= CMP_W'(length_q[s])) || (nxt >= CMP_W'(KEY_LEN));
    assign lane_letter[s] = lane_on ? store_q[cur_idx] : 5'd0;

    // Cursor and length of this key.
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cursor_q[s] <= '0;
        length_q[s] <= LEN_W'(1);
      end else if (end_fire && sel) begin
        cursor_q[s] <= '0;
        length_q[s] <= LEN_W'({1'b0, head_i.pos} + 5'd1);
      end else if (enc_fire && lane_on) begin
        cursor_q[s] <= wrap ? '0 : nxt[CUR_W-1:0];
      end
    end

    // Key letters of this key; undefined until loaded.
    always_ff @(posedge clk_i) begin
      if (load_fire && sel) begin
        store_q[wr_pos] <= head_i.letter;
      end
    end
  end

  // Sum of the current letter of every key in use.
  always_comb begin
    sum = '0;
    for (int k = 0; k < MAX_KEYS; k++) begin
      sum = sum + SUM_W'(lane_letter[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r1_valid_q <= 1'b0;
    end else if (pop_o && !is_load) begin
      r1_valid_q <= 1'b1;
    end else if (out_load) begin
      r1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && !is_load) begin
      r1_letter_q <= (head_i.op == OP_LETTER);
      r1_byte_q   <= head_i.data;
      r1_sum_q    <= sum;
    end
  end

  // Shift the letter by the reduced sum.
  assign offset = r1_byte_q - ASCII_A;
  assign mod_in = MOD_W'(offset[4:0]) + MOD_W'(r1_sum_q);
  assign cipher = r1_letter_q ? (ASCII_A + 8'(mod_alpha(mod_in))) : r1_byte_q;

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= r1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && r1_valid_q) begin
      out_byte_q <= cipher;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign cipher_byte_o = out_byte_q;

  for (genvar a = 0; a < MAX_KEYS; a++) begin : g_chk
    `MKV_ASSERT_IMPL(a_cursor_in_key, 1'b1, CMP_W'(cursor_q[a]) < CMP_W'(length_q[a]),
                     "key cursor past key length")
  end
  `MKV_ASSERT_NEXT(a_r1_hold, r1_valid_q && !out_load,
                   r1_valid_q && $stable(r1_sum_q) && $stable(r1_byte_q),
                   "result stage overwritten while held")
  `MKV_ASSERT_NEXT(a_out_hold, out_valid_q && !out_ready_i,
                   out_valid_q && $stable(out_byte_q), "output changed while stalled")

endmodule

// File: sim/tb_multi_key_vigenere_encrypt.sv
`timescale 1ns / 100ps
// Self-checking testbench for multi_key_vigenere_encrypt: key loads and data bytes
// on valid/ready channels, checked against an in-bench cipher predictor.
// Depends on mkv_pkg and the multi_key_vigenere_encrypt RTL.
module tb_multi_key_vigenere_encrypt;
  import mkv_pkg::*;

  localparam int CLK_PERIOD    = 8;
  localparam int NUM_SLOTS     = 8;
  localparam int KEY_DEPTH     = 16;
  localparam int SETTLE_CYCLES = 12;
  localparam int STALL_LIMIT   = 2000;
  localparam int LONG_HOLD     = 300;
  localparam int MAX_PRINTED   = 100;

  typedef struct {
    logic [7:0]  plain;
    logic [7:0]  cipher;
    int unsigned seq;
  } cipher_exp_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [3:0] cfg_data_i;
  logic       in_valid_i;
  logic       in_ready_o;
  logic       command_i;
  logic [2:0] key_slot_i;
  logic [3:0] key_position_i;
  logic [4:0] key_letter_i;
  logic       key_end_i;
  logic [7:0] data_byte_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] cipher_byte_o;

  // Shadow copy of the key registers and the keys_in_use setting.
  logic [4:0] key_mem     [NUM_SLOTS][KEY_DEPTH];
  bit         key_written [NUM_SLOTS][KEY_DEPTH];
  logic [4:0] key_len_q   [NUM_SLOTS];
  logic [3:0] cursor_q    [NUM_SLOTS];
  logic [3:0] lanes_cfg;

  cipher_exp_t cipher_expected[$];

  int send_idle_pct     = 20;
  int sink_stall_pct    = 20;
  int sink_hold_request = 0;
  int stall_cycles      = 0;
  int n_errors          = 0;
  int n_items           = 0;
  int n_loads           = 0;
  int n_bytes           = 0;
  int n_letters         = 0;
  int n_checked         = 0;
  int n_cfg_writes      = 0;

  multi_key_vigenere_encrypt DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .key_slot_i     (key_slot_i),
    .key_position_i (key_position_i),
    .key_letter_i   (key_letter_i),
    .key_end_i      (key_end_i),
    .data_byte_i    (data_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .cipher_byte_o  (cipher_byte_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Cipher predictor.

  // Put the shadow registers into their reset state.
  function automatic void reset_key_model();
    for (int s = 0; s < NUM_SLOTS; s++) begin
      key_len_q[s] = 5'd1;
      cursor_q[s]  = 4'd0;
      for (int p = 0; p < KEY_DEPTH; p++) begin
        key_mem[s][p]     = 5'd0;
        key_written[s][p] = 1'b0;
      end
    end
    lanes_cfg = 4'd1;
  endfunction

  // A load writes one letter; an end mark also sets the length and rewinds the key.
  function automatic void store_key_letter(logic [2:0] slot, logic [3:0] pos,
                                           logic [4:0] letter, logic kend);
    key_mem[slot][pos]     = letter;
    key_written[slot][pos] = 1'b1;
    if (kend) begin
      key_len_q[slot] = {1'b0, pos} + 5'd1;
      cursor_q[slot]  = 4'd0;
    end
  endfunction

  // Number of keys that take part, with settings above the slot count saturated.
  function automatic int active_keys();
    return (lanes_cfg > NUM_SLOTS) ? NUM_SLOTS : int'(lanes_cfg);
  endfunction

  // Shift a lower-case letter by the sum of current letters; step each cursor in use.
  function automatic logic [7:0] encrypt_byte(logic [7:0] plain);
    int unsigned sum;
    logic [4:0]  step;
    sum = 0;
    if (plain < ASCII_A || plain > ASCII_Z) begin
      return plain;
    end
    for (int s = 0; s < active_keys(); s++) begin
      sum += key_mem[s][cursor_q[s]];
      step = {1'b0, cursor_q[s]} + 5'd1;
      if (step >= key_len_q[s] || step >= KEY_DEPTH) begin
        step = 5'd0;
      end
      cursor_q[s] = step[3:0];
    end
    return 8'(((int'(plain) - int'(ASCII_A) + sum) % ALPHA) + ASCII_A);
  endfunction

  // Reporting and result checking.

  task automatic report_mismatch(input string what);
    n_errors++;
    if (n_errors <= MAX_PRINTED) begin
      $display("%0t ns ERROR: %s", $time, what);
    end
  endtask

  // Receiver: checks each output transaction and drives ready with random stalls.
  // A hold request from a test is taken over and counted down here.
  initial begin : result_sink
    cipher_exp_t exp_item;
    int          hold_left;
    hold_left   = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        if (cipher_expected.size() == 0) begin
          report_mismatch($sformatf("cipher byte %h with no data byte pending",
                                    cipher_byte_o));
        end else begin
          exp_item = cipher_expected.pop_front();
          n_checked++;
          if (cipher_byte_o !== exp_item.cipher) begin
            report_mismatch($sformatf("data byte #%0d (%h): cipher %h, expected %h",
                                      exp_item.seq, exp_item.plain, cipher_byte_o,
                                      exp_item.cipher));
          end
        end
      end
      if (sink_hold_request > 0) begin
        hold_left         = sink_hold_request;
        sink_hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Watchdog: ends the run when no channel completes a transaction for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Stimulus helpers.

  // Offer one input transaction, after an optional random gap, and predict it on accept.
  task automatic send_item(input logic cmd, input logic [2:0] slot, input logic [3:0] pos,
                           input logic [4:0] letter, input logic kend,
                           input logic [7:0] data);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i     <= 1'b1;
    command_i      <= cmd;
    key_slot_i     <= slot;
    key_position_i <= pos;
    key_letter_i   <= letter;
    key_end_i      <= kend;
    data_byte_i    <= data;
    do @(posedge clk_i); while (!in_ready_o);
    n_items++;
    if (cmd == CMD_LOAD) begin
      n_loads++;
      store_key_letter(slot, pos, letter, kend);
    end else begin
      n_bytes++;
      if (data >= ASCII_A && data <= ASCII_Z) begin
        n_letters++;
      end
      cipher_expected.push_back('{plain: data, cipher: encrypt_byte(data), seq: n_bytes});
    end
  endtask

  function automatic logic [4:0] rand_letter();
    return ($urandom_range(99) < 85) ? 5'($urandom_range(25)) : 5'($urandom_range(31, 26));
  endfunction

  // Load one key letter; the unused data field carries random bits.
  task automatic send_load(input logic [2:0] slot, input logic [3:0] pos,
                           input logic [4:0] letter, input logic kend);
    send_item(CMD_LOAD, slot, pos, letter, kend, 8'($urandom));
  endtask

  // Before a letter is encrypted, load any key letter under a cursor that was never
  // written, so that no undefined key entry is ever read.
  task automatic fill_pending_letters();
    for (int s = 0; s < active_keys(); s++) begin
      if (!key_written[s][cursor_q[s]]) begin
        send_load(3'(s), cursor_q[s], rand_letter(), 1'b0);
      end
    end
  endtask

  // Encrypt one byte; the unused key fields carry random bits.
  task automatic send_byte(input logic [7:0] data);
    if (data >= ASCII_A && data <= ASCII_Z) begin
      fill_pending_letters();
    end
    send_item(CMD_ENCRYPT, 3'($urandom), 4'($urandom), 5'($urandom), 1'($urandom), data);
  endtask

  // Load a whole key, end mark on its last letter.
  task automatic load_key(input logic [2:0] slot, input int len);
    for (int p = 0; p < len; p++) begin
      send_load(slot, 4'(p), rand_letter(), p == len - 1);
    end
  endtask

  // One random step: mostly letters, some loose loads and now and then a whole key.
  task automatic send_random_item();
    int         pick;
    int         len;
    logic [2:0] slot;
    pick = $urandom_range(99);
    slot = (active_keys() > 0 && $urandom_range(99) < 70) ?
           3'($urandom_range(active_keys() - 1)) : 3'($urandom);
    if (pick < 6) begin
      len = ($urandom_range(99) < 80) ? $urandom_range(4, 1) : $urandom_range(KEY_DEPTH, 1);
      load_key(slot, len);
    end else if (pick < 22) begin
      send_load(slot, 4'($urandom), rand_letter(), 1'($urandom));
    end else if (pick < 80) begin
      send_byte(ASCII_A + 8'($urandom_range(25)));
    end else begin
      send_byte(8'($urandom));
    end
  endtask

  // Stop offering input, wait for every pending cipher byte, then let trailing
  // loads drain out of the queue.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (cipher_expected.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write keys_in_use once the block is idle.
  task automatic write_keys_in_use(input logic [3:0] value);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    lanes_cfg = value;
    n_cfg_writes++;
  endtask

  // Tests.

  // Pass-through bytes, letter edges, key letters above z, loads without an end mark
  // and the highest slot and position, all with one key in use.
  task automatic test_directed();
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(8'd65);
    send_byte(ASCII_A - 8'd1);
    send_byte(ASCII_Z + 8'd1);
    send_load(3'd0, 4'd0, 5'd0, 1'b1);
    send_byte(ASCII_A);
    send_byte(ASCII_Z);
    send_load(3'd0, 4'd0, 5'd25, 1'b1);
    send_byte(ASCII_A + 8'd1);
    send_load(3'd0, 4'd1, 5'd31, 1'b1);
    repeat (3) send_byte(ASCII_A);
    send_load(3'd0, 4'd0, 5'd3, 1'b0);
    send_byte(ASCII_A);
    send_byte(ASCII_Z);
    send_load(3'd7, 4'd15, 5'd31, 1'b1);
    send_load(3'd7, 4'd15, 5'd26, 1'b0);
    send_byte(ASCII_A + 8'd12);
  endtask

  // No keys, one key, all keys, saturated settings and a random one.
  task automatic test_keys_in_use_sweep();
    logic [3:0] settings [6];
    settings = '{4'd0, 4'd1, 4'd8, 4'd9, 4'd15, 4'($urandom_range(7, 2))};
    foreach (settings[i]) begin
      write_keys_in_use(settings[i]);
      repeat (12) send_random_item();
    end
  endtask

  // Long random stream with random idling on both sides and a new setting now and then.
  task automatic test_random_stream();
    for (int i = 0; i < 160; i++) begin
      if (i % 40 == 39) begin
        write_keys_in_use(4'($urandom));
      end
      send_random_item();
    end
  endtask

  // A stretch with neither side idling.
  task automatic test_no_idle();
    send_idle_pct  = 0;
    sink_stall_pct = 0;
    write_keys_in_use(4'd8);
    repeat (50) send_random_item();
    send_idle_pct  = 20;
    sink_stall_pct = 20;
  endtask

  // The receiver holds off for a long stretch while input keeps coming, so the
  // internal queue fills and input ready drops; then everything drains.
  task automatic test_backpressure();
    send_idle_pct     = 0;
    sink_hold_request = LONG_HOLD;
    repeat (40) send_byte(ASCII_A + 8'($urandom_range(25)));
    send_idle_pct = 20;
    wait_idle();
  endtask

  // Main sequence.
  initial begin : main_sequence
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = 4'd0;
    in_valid_i     = 1'b0;
    command_i      = CMD_LOAD;
    key_slot_i     = 3'd0;
    key_position_i = 4'd0;
    key_letter_i   = 5'd0;
    key_end_i      = 1'b0;
    data_byte_i    = 8'd0;
    reset_key_model();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_keys_in_use_sweep();
    test_random_stream();
    test_no_idle();
    test_backpressure();
    wait_idle();

    if (cipher_expected.size() != 0) begin
      report_mismatch($sformatf("%0d cipher bytes never arrived", cipher_expected.size()));
    end
    $display("Sent %0d items: %0d key loads, %0d data bytes (%0d letters), %0d checked.",
             n_items, n_loads, n_bytes, n_letters, n_checked);
    $display("Wrote keys_in_use %0d times, including 0, 1, 8, 9 and 15; held output %0d cycles.",
             n_cfg_writes, LONG_HOLD);
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/mkv_pkg.sv
hw/rtl/mkv_front.sv
hw/rtl/mkv_queue.sv
hw/rtl/mkv_back.sv
hw/rtl/multi_key_vigenere_encrypt.sv
sim/tb_multi_key_vigenere_encrypt.sv
